>>> src/sbht_pkg.sv
// Shared types, widths and constants for the segment/box hit test core.
// Used by every module of the core; depends on nothing.
package sbht_pkg;

   localparam int CoordWidth = 32;
   localparam int FracBits   = 16;
   localparam int DenWidth   = CoordWidth;
   localparam int QuoWidth   = CoordWidth - 1;
   localparam int NumWidth   = CoordWidth + FracBits;
   localparam int NumSides   = 4;

   localparam logic signed [CoordWidth-1:0] TMin = {1'b1, {(CoordWidth-1){1'b0}}};
   localparam logic signed [CoordWidth-1:0] TMax = {1'b0, {(CoordWidth-1){1'b1}}};
   localparam logic signed [CoordWidth-1:0] TOne =
      CoordWidth'(64'd1 << FracBits);

   typedef logic signed [CoordWidth-1:0] coord_type;

   typedef enum logic [1:0] {
      REG_BOX_LEFT   = 2'd0,
      REG_BOX_RIGHT  = 2'd1,
      REG_BOX_BOTTOM = 2'd2,
      REG_BOX_TOP    = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic                 pzero;
      logic                 pneg;
      logic                 qneg;
      logic                 ovf;
      logic [DenWidth-1:0]  den;
      logic [DenWidth-1:0]  rem;
      logic [QuoWidth-1:0]  low;
      logic [QuoWidth-1:0]  quo;
   } side_type;

   typedef struct packed {
      logic                          valid;
      side_type [NumSides-1:0]       side;
   } stage_type;

   typedef struct packed {
      coord_type left;
      coord_type right;
      coord_type bottom;
      coord_type top;
   } box_type;

endpackage

>>> src/sbht_prep.sv
// Front cell: forms p, q, magnitudes and the overflow flag for each box side.
// Depends on sbht_pkg.
module sbht_prep (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  sbht_pkg::coord_type sx,
   input  sbht_pkg::coord_type sy,
   input  sbht_pkg::coord_type dx,
   input  sbht_pkg::coord_type dy,
   input  sbht_pkg::box_type box,
   output sbht_pkg::stage_type out
);
   import sbht_pkg::*;

   stage_type stage_ff, stage_in;
   logic signed [CoordWidth:0] p [NumSides];
   logic signed [CoordWidth:0] q [NumSides];
   logic [NumWidth-1:0]        num [NumSides];
   logic [DenWidth-1:0]        pm [NumSides];
   logic [CoordWidth-1:0]      qm [NumSides];

   always_comb begin
      p[0] = -(CoordWidth+1)'(dx);
      p[1] =  (CoordWidth+1)'(dx);
      p[2] = -(CoordWidth+1)'(dy);
      p[3] =  (CoordWidth+1)'(dy);
      q[0] = (CoordWidth+1)'(sx) - (CoordWidth+1)'(box.left);
      q[1] = (CoordWidth+1)'(box.right) - (CoordWidth+1)'(sx);
      q[2] = (CoordWidth+1)'(sy) - (CoordWidth+1)'(box.bottom);
      q[3] = (CoordWidth+1)'(box.top) - (CoordWidth+1)'(sy);
      stage_in.valid = in_valid;
      for (int i = 0; i < NumSides; i++) begin
         pm[i] = DenWidth'(p[i][CoordWidth] ? -p[i] : p[i]);
         qm[i] = CoordWidth'(q[i][CoordWidth] ? -q[i] : q[i]);
         num[i] = {qm[i], {FracBits{1'b0}}};
         stage_in.side[i].pzero = (p[i] == '0);
         stage_in.side[i].pneg  = p[i][CoordWidth];
         stage_in.side[i].qneg  = q[i][CoordWidth];
         stage_in.side[i].ovf   =
            ((2*CoordWidth)'(num[i]) >= ((2*CoordWidth)'(pm[i]) << (CoordWidth-1)));
         stage_in.side[i].den   = pm[i];
         stage_in.side[i].rem   = DenWidth'(num[i] >> (CoordWidth-1));
         stage_in.side[i].low   = num[i][QuoWidth-1:0];
         stage_in.side[i].quo   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else if (en) begin
         stage_ff <= stage_in;
      end
   end

   assign out = stage_ff;

endmodule

>>> src/sbht_div_cell.sv
// One restoring-division cell: retires one quotient bit for all four sides.
// Depends on sbht_pkg.
module sbht_div_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  sbht_pkg::stage_type in,
   output sbht_pkg::stage_type out
);
   import sbht_pkg::*;

   stage_type stage_ff, stage_in;
   logic [DenWidth:0] trial [NumSides];
   logic              take  [NumSides];

   always_comb begin
      stage_in = in;
      for (int i = 0; i < NumSides; i++) begin
         trial[i] = {in.side[i].rem, in.side[i].low[QuoWidth-1]};
         take[i]  = (trial[i] >= {1'b0, in.side[i].den});
         stage_in.side[i].rem = take[i] ? DenWidth'(trial[i] - {1'b0, in.side[i].den})
                                        : DenWidth'(trial[i]);
         stage_in.side[i].low = in.side[i].low << 1;
         stage_in.side[i].quo = {in.side[i].quo[QuoWidth-2:0], take[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else if (en) begin
         stage_ff <= stage_in;
      end
   end

   assign out = stage_ff;

endmodule

>>> src/sbht_resolve.sv
// Back cells: signs and saturates the quotients, clips t0/t1, drives result.
// Depends on sbht_pkg.
module sbht_resolve (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  sbht_pkg::stage_type in,
   output logic                out_valid,
   output logic                out_hit,
   output sbht_pkg::coord_type out_t
);
   import sbht_pkg::*;

   coord_type t_ff [NumSides];
   coord_type t_in [NumSides];
   logic [NumSides-1:0] act_ff, act_in, neg_ff, neg_in;
   logic miss_ff, miss_in, valid_ff;
   logic hit_ff, hit_in, rvalid_ff;
   coord_type ent_ff, ent_in;
   coord_type t0, t1;
   logic [CoordWidth-1:0] m;

   always_comb begin
      miss_in = 1'b0;
      for (int i = 0; i < NumSides; i++) begin
         m = {1'b0, in.side[i].quo};
         act_in[i] = !in.side[i].pzero;
         neg_in[i] = in.side[i].pneg;
         if (in.side[i].ovf) begin
            t_in[i] = (in.side[i].qneg ^ in.side[i].pneg) ? TMin : TMax;
         end else begin
            t_in[i] = (in.side[i].qneg ^ in.side[i].pneg) ? -coord_type'(m) : coord_type'(m);
         end
         if (in.side[i].pzero && in.side[i].qneg) begin
            miss_in = 1'b1;
         end
      end
   end

   always_comb begin
      t0 = TMin;
      t1 = TMax;
      for (int i = 0; i < NumSides; i++) begin
         if (act_ff[i]) begin
            if (neg_ff[i]) begin
               if (t_ff[i] > t0) begin
                  t0 = t_ff[i];
               end
            end else if (t_ff[i] < t1) begin
               t1 = t_ff[i];
            end
         end
      end
      hit_in = !miss_ff && (t0 < t1) && (t1 > 0) && (t0 < TOne);
      ent_in = hit_in ? t0 : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         rvalid_ff <= 1'b0;
      end else if (en) begin
         valid_ff  <= in.valid;
         rvalid_ff <= valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t_ff    <= t_in;
         act_ff  <= act_in;
         neg_ff  <= neg_in;
         miss_ff <= miss_in;
         hit_ff  <= hit_in;
         ent_ff  <= ent_in;
      end
   end

   assign out_valid = rvalid_ff;
   assign out_hit   = hit_ff;
   assign out_t     = ent_ff;

endmodule

>>> src/segment_box_hit_test_core.sv
// Top level of the segment/box hit test core: box registers and cell chain.
// Depends on sbht_pkg, sbht_prep, sbht_div_cell and sbht_resolve.
//
//   channel | ports             | moves
//   --------+-------------------+-------------------------------------------
//   req     | req_valid/stall   | start_x, start_y, delta_x, delta_y
//   rsp     | rsp_valid/stall   | hit, entry_t
//   csr     | csr_write_enable  | box_left, box_right, box_bottom, box_top
//
// One segment per cycle while not stalled; the chain is a front cell,
// 31 division cells (one quotient bit each) and two back cells.
// Reset clears all valid flags and the box registers.
// The whole chain holds while a result waits under rsp_stall; req_stall
// follows that hold.
module segment_box_hit_test_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [31:0]         req_start_x,
   input  logic signed [31:0]         req_start_y,
   input  logic signed [31:0]         req_delta_x,
   input  logic signed [31:0]         req_delta_y,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_hit,
   output logic signed [31:0]         rsp_entry_t,
   input  logic                       csr_write_enable,
   input  logic [1:0]                 csr_index,
   input  logic [31:0]                csr_write_data
);
   import sbht_pkg::*;

   box_type   box_ff;
   logic      en;
   stage_type chain [QuoWidth+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         box_ff <= '0;
      end else if (csr_write_enable) begin
         case (reg_index_type'(csr_index))
            REG_BOX_LEFT:   box_ff.left   <= csr_write_data;
            REG_BOX_RIGHT:  box_ff.right  <= csr_write_data;
            REG_BOX_BOTTOM: box_ff.bottom <= csr_write_data;
            REG_BOX_TOP:    box_ff.top    <= csr_write_data;
            default:        box_ff        <= box_ff;
         endcase
      end
   end

   assign en        = !rsp_valid || !rsp_stall;
   assign req_stall = !en;

   sbht_prep u_prep (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_valid),
      .sx       (req_start_x),
      .sy       (req_start_y),
      .dx       (req_delta_x),
      .dy       (req_delta_y),
      .box      (box_ff),
      .out      (chain[0])
   );

   for (genvar k = 0; k < QuoWidth; k++) begin : g_div
      sbht_div_cell u_cell (
         .clock (clock),
         .reset (reset),
         .en    (en),
         .in    (chain[k]),
         .out   (chain[k+1])
      );
   end

   sbht_resolve u_resolve (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in        (chain[QuoWidth]),
      .out_valid (rsp_valid),
      .out_hit   (rsp_hit),
      .out_t     (rsp_entry_t)
   );

endmodule

>>> src/sbht_checker.sv
// Port-level checks for the segment/box hit test core, bound to the top level.
// Depends on sbht_pkg and segment_box_hit_test_core.
module sbht_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic               rsp_hit,
   input logic signed [31:0] rsp_entry_t
);
   import sbht_pkg::*;

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_entry_t == '0)
      else $error("miss with nonzero entry_t");

   a_hit_below_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> rsp_entry_t < TOne)
      else $error("hit with entry_t at or above one");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_entry_t) && $stable(rsp_hit))
      else $error("stalled result changed");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a waiting result");

endmodule

bind segment_box_hit_test_core sbht_checker u_sbht_checker (
   .clock       (clock),
   .reset       (reset),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_hit     (rsp_hit),
   .rsp_entry_t (rsp_entry_t)
);
